// ===== rtl/archive_name_utf8_validator_defines.svh =====
// Assertion helpers for the name validator.
`ifndef ARCHIVE_NAME_UTF8_VALIDATOR_DEFINES_SVH
`define ARCHIVE_NAME_UTF8_VALIDATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define AUNV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AUNV_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define AUNV_ASSERT(lbl, prop, msg)
`define AUNV_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/aunv_pkg.sv =====
package aunv_pkg;

  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned MAXLEN_W = 16;
  localparam int unsigned SCALAR_W = 21;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 17'h10000;
  localparam logic [MAXLEN_W-1:0] MAX_NAME_RESET = 16'd4096;

  // configuration register indexes
  localparam logic CFG_MAX_NAME_BYTES = 1'b0;
  localparam logic CFG_ENCODING       = 1'b1;

  localparam logic ENC_STRICT_UTF8 = 1'b0;

  typedef enum logic [1:0] {
    STATUS_VALID       = 2'd0,
    STATUS_UNSUPPORTED = 2'd1,
    STATUS_BAD_NAME    = 2'd2,
    STATUS_BAD_UTF8    = 2'd3
  } status_t;

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  localparam logic [SCALAR_W-1:0] MIN_LEN2   = 21'h80;
  localparam logic [SCALAR_W-1:0] MIN_LEN3   = 21'h800;
  localparam logic [SCALAR_W-1:0] MIN_LEN4   = 21'h10000;
  localparam logic [SCALAR_W-1:0] MAX_SCALAR = 21'h10FFFF;
  localparam logic [SCALAR_W-1:0] SURR_LO    = 21'hD800;
  localparam logic [SCALAR_W-1:0] SURR_HI    = 21'hDFFF;

  typedef struct packed {
    logic [1:0]          pending;
    logic [2:0]          seq_len;
    logic [SCALAR_W-1:0] acc;
    logic                failed;
  } utf8_state_t;

endpackage

// ===== rtl/aunv_decode.sv =====
module aunv_decode (
  input  aunv_pkg::utf8_state_t cur,
  input  logic [7:0]            data,
  input  logic                  en,
  output aunv_pkg::utf8_state_t nxt
);
  import aunv_pkg::*;

  logic [SCALAR_W-1:0] acc_shift;
  logic [SCALAR_W-1:0] minimum;
  utf8_state_t         fail_state;

  assign acc_shift = {cur.acc[SCALAR_W-7:0], data[5:0]};

  always_comb begin
    case (cur.seq_len)
      SEQ_LEN2: minimum = MIN_LEN2;
      SEQ_LEN3: minimum = MIN_LEN3;
      default:  minimum = MIN_LEN4;
    endcase
  end

  always_comb begin
    fail_state         = '0;
    fail_state.failed  = 1'b1;
    nxt = cur;
    if (en && !cur.failed) begin
      if (cur.pending == 2'd0) begin
        if (!data[7]) begin
          nxt = cur;
        end else if (data >= LEAD2_LO && data <= LEAD2_HI) begin
          nxt.seq_len = SEQ_LEN2;
          nxt.pending = 2'd1;
          nxt.acc     = {16'd0, data[4:0]};
        end else if (data >= LEAD3_LO && data <= LEAD3_HI) begin
          nxt.seq_len = SEQ_LEN3;
          nxt.pending = 2'd2;
          nxt.acc     = {17'd0, data[3:0]};
        end else if (data >= LEAD4_LO && data <= LEAD4_HI) begin
          nxt.seq_len = SEQ_LEN4;
          nxt.pending = 2'd3;
          nxt.acc     = {18'd0, data[2:0]};
        end else begin
          nxt = fail_state;
        end
      end else if (data[7:6] != 2'b10) begin
        nxt = fail_state;
      end else begin
        nxt.acc     = acc_shift;
        nxt.pending = cur.pending - 2'd1;
        if (cur.pending == 2'd1) begin
          // sequence complete: reject overlong, surrogate and out-of-range values
          if (acc_shift < minimum || acc_shift > MAX_SCALAR ||
              (acc_shift >= SURR_LO && acc_shift <= SURR_HI)) begin
            nxt = fail_state;
          end else begin
            nxt.seq_len = SEQ_NONE;
            nxt.acc     = '0;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/aunv_verdict.sv =====
module aunv_verdict (
  input  logic                            encoding_choice,
  input  logic [aunv_pkg::MAXLEN_W-1:0]   max_name_bytes,
  input  logic [aunv_pkg::COUNT_W-1:0]    byte_count,
  input  logic                            nul_seen,
  input  aunv_pkg::utf8_state_t           dec,
  output aunv_pkg::status_t               status
);
  import aunv_pkg::*;

  logic too_long;

  assign too_long = byte_count > {1'b0, max_name_bytes};

  always_comb begin
    if (encoding_choice != ENC_STRICT_UTF8) begin
      status = STATUS_UNSUPPORTED;
    end else if (byte_count == '0 || too_long || nul_seen) begin
      status = STATUS_BAD_NAME;
    end else if (dec.failed || dec.pending != 2'd0) begin
      status = STATUS_BAD_UTF8;
    end else begin
      status = STATUS_VALID;
    end
  end

endmodule

// ===== rtl/archive_name_utf8_validator.sv =====
// Strict UTF-8 checker for archive member names. Bytes arrive one per input
// transaction; the transaction flagged is_last closes the name and yields a
// single verdict (status plus saturated byte count), others yield nothing.
// Throughput is one byte per clock: an input register feeds the combinational
// decode and count update, which loads the result register, so a verdict
// passes through the input register and then the result register after its
// last byte is taken. The result register lets new bytes flow in while a
// verdict waits; only the next name's last byte stalls until that verdict is
// taken. Config writes apply at once and belong between names.
`include "archive_name_utf8_validator_defines.svh"

module archive_name_utf8_validator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [aunv_pkg::MAXLEN_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    name_byte,
  input  logic                          no_byte,
  input  logic                          is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [aunv_pkg::COUNT_W-1:0]  name_length
);
  import aunv_pkg::*;

  logic [MAXLEN_W-1:0] max_name_bytes;
  logic                encoding_choice;

  // input stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_no_byte;
  logic       s1_last;
  logic       s1_advance;

  // per-name state
  utf8_state_t        dec;
  utf8_state_t        dec_next;
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic               nul_seen;
  logic               nul_seen_next;
  status_t            verdict;

  assign s1_advance = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  aunv_decode u_decode (
    .cur  (dec),
    .data (s1_byte),
    .en   (!s1_no_byte),
    .nxt  (dec_next)
  );

  always_comb begin
    byte_count_next = byte_count;
    nul_seen_next   = nul_seen;
    if (!s1_no_byte) begin
      if (byte_count != COUNT_LIMIT) begin
        byte_count_next = byte_count + COUNT_W'(1);
      end
      if (s1_byte == 8'd0) begin
        nul_seen_next = 1'b1;
      end
    end
  end

  aunv_verdict u_verdict (
    .encoding_choice (encoding_choice),
    .max_name_bytes  (max_name_bytes),
    .byte_count      (byte_count_next),
    .nul_seen        (nul_seen_next),
    .dec             (dec_next),
    .status          (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_bytes  <= MAX_NAME_RESET;
      encoding_choice <= ENC_STRICT_UTF8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_NAME_BYTES: max_name_bytes  <= cfg_data;
        CFG_ENCODING:       encoding_choice <= cfg_data[0];
        default:            max_name_bytes  <= max_name_bytes;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte    <= name_byte;
      s1_no_byte <= no_byte;
      s1_last    <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec        <= '0;
      byte_count <= '0;
      nul_seen   <= 1'b0;
    end else if (s1_advance) begin
      if (s1_last) begin
        dec        <= '0;
        byte_count <= '0;
        nul_seen   <= 1'b0;
      end else begin
        dec        <= dec_next;
        byte_count <= byte_count_next;
        nul_seen   <= nul_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last) begin
      status      <= verdict;
      name_length <= byte_count_next;
    end
  end

  `AUNV_NEVER(a_pending_consistent,
    dec.pending != 2'd0 && (dec.failed || dec.seq_len <= 3'(dec.pending)),
    "pending bytes without an open sequence")
  `AUNV_NEVER(a_failed_clean,
    dec.failed && (dec.pending != 2'd0 || dec.seq_len != SEQ_NONE),
    "failed state still holds a sequence")
  `AUNV_NEVER(a_count_bound, byte_count > COUNT_LIMIT, "byte counter past saturation")
  `AUNV_ASSERT(a_valid_len,
    out_valid && status == STATUS_VALID |->
      name_length != '0 && name_length <= COUNT_W'(max_name_bytes),
    "valid verdict with bad length")

endmodule
